[sv/esg_pkg.sv]
// Shared constants, types and arithmetic helpers of the exponential sweep generator.
package esg_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int COUNT_BITS      = 24;
	localparam int SIN_Q           = SINE_TABLE_BITS - 2;
	localparam int SIN_SHIFT       = 16 - SIN_Q;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int X_W    = 17;

	localparam logic [17:0] SIN_A = 18'd102944;
	localparam logic [17:0] SIN_B = 18'd42048;
	localparam logic [17:0] SIN_C = 18'd4640;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_START_STEP = 3'd0;
	localparam logic [2:0] REG_STEP_RATIO = 3'd1;
	localparam logic [2:0] REG_SWEEP_LEN  = 3'd2;
	localparam logic [2:0] REG_FADE_LEN   = 3'd3;
	localparam logic [2:0] REG_FADE_STEP  = 3'd4;
	localparam logic [2:0] REG_AMPLITUDE  = 3'd5;

	typedef logic signed [MUL_W-1:0]  mul_op_t;
	typedef logic signed [PROD_W-1:0] mul_prod_t;

	// Quarter-wave folded angle, scaled to Q16.
	function automatic logic [X_W-1:0] sine_x(input logic [31:0] ang);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [SIN_Q-1:0] frac;
		logic [SIN_Q:0] xq;
		idx  = ang[31 -: SINE_TABLE_BITS];
		frac = idx[SIN_Q-1:0];
		if (idx[SIN_Q]) begin
			xq = (SIN_Q+1)'(1 << SIN_Q) - {1'b0, frac};
		end else begin
			xq = {1'b0, frac};
		end
		return X_W'(xq) << SIN_SHIFT;
	endfunction

	// Last step of the polynomial: round to Q15, cap and apply the quadrant sign.
	function automatic logic signed [15:0] sine_finish(input mul_prod_t p, input logic [31:0] ang);
		logic [17:0] y;
		logic [17:0] yr;
		logic [15:0] mag;
		y  = p[33:16];
		yr = (y + 18'd1) >> 1;
		if (yr > 18'd32767) begin
			mag = 16'd32767;
		end else begin
			mag = yr[15:0];
		end
		if (ang[31]) begin
			return -$signed(mag);
		end else begin
			return $signed(mag);
		end
	endfunction

	// Q15 product with round half up and saturation to 16 bits.
	function automatic logic signed [15:0] q15_round_sat(input mul_prod_t p);
		mul_prod_t r;
		r = (p + PROD_W'(16384)) >>> 15;
		if (r > PROD_W'(32767)) begin
			return 16'sh7FFF;
		end else if (r < -PROD_W'(32768)) begin
			return -16'sh8000;
		end else begin
			return r[15:0];
		end
	endfunction

endpackage

[sv/exponential_sweep_generator.sv]
// Each tick runs LOAD, the sine polynomial (X2, C, I1, I2, Y), AMP, AMPR, UPD and OUT; in a fade
// ANG, a second sine pass, GAIN and GAINR follow AMPR; with no sweep running LOAD goes to OUT. The
// next tick is taken only once the sequencer returns to idle, even while the previous sample still
// waits on the output register. All products share one 33x33 multiplier (6 products, 12 in a fade).
// Reset is asynchronous and active low; it clears control state, registers to reset values.
module exponential_sweep_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast,   // last_sample
	output logic        m_tuser,   // [0] active
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [esg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_LOAD  = 14'b00000000000010,
		ST_X2    = 14'b00000000000100,
		ST_C     = 14'b00000000001000,
		ST_I1    = 14'b00000000010000,
		ST_I2    = 14'b00000000100000,
		ST_Y     = 14'b00000001000000,
		ST_AMP   = 14'b00000010000000,
		ST_AMPR  = 14'b00000100000000,
		ST_ANG   = 14'b00001000000000,
		ST_GAIN  = 14'b00010000000000,
		ST_GAINR = 14'b00100000000000,
		ST_UPD   = 14'b01000000000000,
		ST_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [30:0] start_q;
	logic [31:0] ratio_q;
	logic [23:0] len_q;
	logic [22:0] fadel_q;
	logic [30:0] fas_q;
	logic signed [15:0] amp_q;

	logic [31:0] phase_q;
	logic [31:0] step_q;
	logic [esg_pkg::COUNT_BITS-1:0] cnt_q;
	logic        running_q;

	logic [31:0] ang_q;
	logic [esg_pkg::X_W-1:0] x2_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] s_q;
	logic signed [15:0] gain_q;
	logic [esg_pkg::COUNT_BITS-1:0] fi_q;
	logic        in_fade_q;
	logic        last_q;
	logic        pass_q;
	logic        res_active_q;

	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_last_q;
	logic        out_active_q;

	esg_pkg::mul_op_t   mul_a;
	esg_pkg::mul_op_t   mul_b;
	esg_pkg::mul_prod_t p_q;

	logic [esg_pkg::X_W-1:0] x_w;
	logic [17:0] inner1_w;
	logic [17:0] inner2_w;
	logic signed [15:0] sin_w;
	logic signed [16:0] gain_w;
	logic [31:0] step_next_w;

	logic [esg_pkg::COUNT_BITS-1:0] len_w;
	logic [esg_pkg::COUNT_BITS-1:0] half_w;
	logic [esg_pkg::COUNT_BITS-1:0] fade_w;
	logic [esg_pkg::COUNT_BITS-1:0] tail_w;
	logic        last_w;

	logic        in_acc;
	logic        cfg_wr;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_active_q;

	esg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// Sweep geometry for the current sample; length zero behaves as one.
	always_comb begin
		len_w  = (len_q == '0) ? esg_pkg::COUNT_BITS'(1) : len_q;
		half_w = len_w >> 1;
		fade_w = ({1'b0, fadel_q} > half_w) ? half_w : {1'b0, fadel_q};
		tail_w = len_w - esg_pkg::COUNT_BITS'(1) - cnt_q;
		last_w = ({1'b0, cnt_q} + (esg_pkg::COUNT_BITS+1)'(1)) >= {1'b0, len_w};
	end

	always_comb begin
		x_w      = esg_pkg::sine_x(ang_q);
		inner1_w = esg_pkg::SIN_B - {2'b00, p_q[31:16]};
		inner2_w = esg_pkg::SIN_A - {1'b0, p_q[32:16]};
		sin_w    = esg_pkg::sine_finish(p_q, ang_q);
		gain_w   = (17'sd32768 - 17'(sin_w)) >>> 1;
		if (p_q[65:31] > 35'h0_FFFF_FFFF) begin
			step_next_w = 32'hFFFF_FFFF;
		end else begin
			step_next_w = p_q[62:31];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_X2: begin
				mul_a = esg_pkg::MUL_W'(x_w);
				mul_b = esg_pkg::MUL_W'(x_w);
			end
			ST_C: begin
				mul_a = esg_pkg::MUL_W'(p_q[32:16]);
				mul_b = esg_pkg::MUL_W'(esg_pkg::SIN_C);
			end
			ST_I1: begin
				mul_a = esg_pkg::MUL_W'(x2_q);
				mul_b = esg_pkg::MUL_W'(inner1_w);
			end
			ST_I2: begin
				mul_a = esg_pkg::MUL_W'(x_w);
				mul_b = esg_pkg::MUL_W'(inner2_w);
			end
			ST_AMP: begin
				mul_a = esg_pkg::MUL_W'(sin_q);
				mul_b = esg_pkg::MUL_W'(amp_q);
			end
			ST_AMPR: begin
				if (in_fade_q) begin
					mul_a = esg_pkg::MUL_W'(fi_q);
					mul_b = esg_pkg::MUL_W'(fas_q);
				end else begin
					mul_a = esg_pkg::MUL_W'(step_q);
					mul_b = esg_pkg::MUL_W'(ratio_q);
				end
			end
			ST_GAIN: begin
				mul_a = esg_pkg::MUL_W'(s_q);
				mul_b = esg_pkg::MUL_W'(gain_q);
			end
			ST_GAINR: begin
				mul_a = esg_pkg::MUL_W'(step_q);
				mul_b = esg_pkg::MUL_W'(ratio_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			ratio_q <= 32'h8000_0000;
			len_q   <= 24'd16;
			fadel_q <= '0;
			fas_q   <= '0;
			amp_q   <= 16'sh7FFF;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				esg_pkg::REG_START_STEP: start_q <= pwdata[30:0];
				esg_pkg::REG_STEP_RATIO: ratio_q <= pwdata;
				esg_pkg::REG_SWEEP_LEN:  len_q   <= pwdata[23:0];
				esg_pkg::REG_FADE_LEN:   fadel_q <= pwdata[22:0];
				esg_pkg::REG_FADE_STEP:  fas_q   <= pwdata[30:0];
				esg_pkg::REG_AMPLITUDE:  amp_q   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			esg_pkg::REG_START_STEP: prdata = {1'b0, start_q};
			esg_pkg::REG_STEP_RATIO: prdata = ratio_q;
			esg_pkg::REG_SWEEP_LEN:  prdata = {8'h00, len_q};
			esg_pkg::REG_FADE_LEN:   prdata = {9'h000, fadel_q};
			esg_pkg::REG_FADE_STEP:  prdata = {1'b0, fas_q};
			esg_pkg::REG_AMPLITUDE:  prdata = {16'h0000, amp_q};
			default:                 prdata = '0;
		endcase
	end

	// Sequencer and sweep state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tdata[0]) begin
							phase_q   <= '0;
							step_q    <= {1'b0, start_q};
							cnt_q     <= '0;
							running_q <= 1'b1;
						end
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD:  state_q <= running_q ? ST_X2 : ST_OUT;
				ST_X2:    state_q <= ST_C;
				ST_C:     state_q <= ST_I1;
				ST_I1:    state_q <= ST_I2;
				ST_I2:    state_q <= ST_Y;
				ST_Y:     state_q <= pass_q ? ST_GAIN : ST_AMP;
				ST_AMP:   state_q <= ST_AMPR;
				ST_AMPR:  state_q <= in_fade_q ? ST_ANG : ST_UPD;
				ST_ANG:   state_q <= ST_X2;
				ST_GAIN:  state_q <= ST_GAINR;
				ST_GAINR: state_q <= ST_UPD;
				ST_UPD: begin
					phase_q <= phase_q + step_q;
					step_q  <= step_next_w;
					cnt_q   <= cnt_q + esg_pkg::COUNT_BITS'(1);
					if (last_q) begin
						running_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Hold here until the output register is free.
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				ang_q        <= phase_q;
				pass_q       <= 1'b0;
				res_active_q <= running_q;
				last_q       <= last_w;
				if (cnt_q < fade_w) begin
					in_fade_q <= 1'b1;
					fi_q      <= cnt_q;
				end else if (cnt_q < len_w && tail_w < fade_w) begin
					in_fade_q <= 1'b1;
					fi_q      <= tail_w;
				end else begin
					in_fade_q <= 1'b0;
					fi_q      <= '0;
				end
			end
			ST_C: x2_q <= p_q[32:16];
			ST_Y: begin
				if (pass_q) begin
					gain_q <= gain_w[15:0];
				end else begin
					sin_q <= sin_w;
				end
			end
			ST_AMPR:  s_q <= esg_pkg::q15_round_sat(p_q);
			ST_ANG: begin
				ang_q  <= p_q[31:0] + esg_pkg::QUARTER_TURN;
				pass_q <= 1'b1;
			end
			ST_GAINR: s_q <= esg_pkg::q15_round_sat(p_q);
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_data_q   <= res_active_q ? s_q : 16'h0000;
					out_last_q   <= res_active_q && last_q;
					out_active_q <= res_active_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[sv/esg_mul.sv]
// Shared signed multiplier with a registered product.
module esg_mul (
	input  logic              clk,
	input  esg_pkg::mul_op_t  a,
	input  esg_pkg::mul_op_t  b,
	output esg_pkg::mul_prod_t p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

[sv/esg_checker.sv]
// Port-level checks for the exponential sweep generator, bound to the top level.
module esg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// A stalled output beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output beat changed while stalled");

	// An inactive beat carries a zero sample and no end mark.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 16'h0000 && !m_tlast)
		else $error("inactive beat is not zero");

	// Only an active beat can end a sweep.
	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last sample marked on inactive beat");

	// After a tick is taken, the sequencer is busy and holds s_tready low.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input accepted while sequencer busy");

endmodule

bind exponential_sweep_generator esg_checker u_esg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

[verif/exponential_sweep_generator_tb.sv]
// Self-checking testbench of the exponential sweep generator: stream ticks in, samples checked.
module exponential_sweep_generator_tb;

	localparam int TBITS = esg_pkg::SINE_TABLE_BITS;
	localparam int QBITS = TBITS - 2;
	localparam longint unsigned POLY_A = 64'd102944;
	localparam longint unsigned POLY_B = 64'd42048;
	localparam longint unsigned POLY_C = 64'd4640;

	typedef struct packed {
		logic [15:0] sample;
		logic        last;
		logic        active;
	} sample_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;     // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;            // [15:0] sample
	logic        m_tlast;            // last_sample
	logic        m_tuser;            // [0] active
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [esg_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	exponential_sweep_generator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Register copies, at their reset values.
	logic [30:0]        cfg_start_step = '0;
	logic [31:0]        cfg_step_ratio = 32'h8000_0000;
	logic [23:0]        cfg_sweep_len = 24'd16;
	logic [22:0]        cfg_fade_len = '0;
	logic [30:0]        cfg_fade_step = '0;
	logic signed [15:0] cfg_amplitude = 16'sh7FFF;

	// Sweep state of the predictor.
	logic [31:0] sw_phase = '0;
	logic [31:0] sw_step = '0;
	logic [23:0] sw_count = '0;
	logic        sw_running = 1'b0;

	logic         tick_queue[$];
	sample_beat_t expected_samples[$];
	int           mismatches = 0;
	int           tick_gap = 0;
	int           stall_left = 0;
	int           hold_left = 0;
	int           beats_seen = 0;
	bit           hold_done = 0;
	bit           idle_on = 1;

	function automatic logic signed [15:0] sine_of(input logic [31:0] ang);
		longint unsigned idx, frac, quad, x, x2, inner, y;
		idx    = ang >> (32 - TBITS);
		frac   = idx & ((64'd1 << QBITS) - 1);
		quad   = (idx >> QBITS) & 64'd3;
		x      = quad[0] ? ((64'd1 << QBITS) - frac) : frac;
		x      = x << (16 - QBITS);
		x2     = (x * x) >> 16;
		inner  = POLY_B - ((x2 * POLY_C) >> 16);
		inner  = POLY_A - ((x2 * inner) >> 16);
		y      = (x * inner) >> 16;
		y      = (y + 1) >> 1;
		if (y > 32767)
			y = 32767;
		if (quad >= 2)
			return -$signed(16'(y));
		return $signed(16'(y));
	endfunction

	function automatic logic signed [15:0] q15_mul(input int a, input int b);
		longint p;
		p = longint'(a) * longint'(b) + 64'sd16384;
		p = p >>> 15;
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		return 16'(p);
	endfunction

	// Advances the sweep by one tick and queues the sample it must produce.
	task automatic predict_sample(input logic restart);
		int unsigned len, fade, n, fi;
		logic [31:0] ang;
		logic in_fade, last;
		int s, c, gain;
		longint unsigned nstep;
		sample_beat_t e;
		if (restart) begin
			sw_phase = '0;
			sw_step = {1'b0, cfg_start_step};
			sw_count = '0;
			sw_running = 1'b1;
		end
		if (!sw_running) begin
			e = '0;
		end else begin
			len = cfg_sweep_len;
			if (len == 0)
				len = 1;
			fade = cfg_fade_len;
			if (fade > len / 2)
				fade = len / 2;
			n = sw_count;
			s = q15_mul(sine_of(sw_phase), cfg_amplitude);
			in_fade = 1'b0;
			fi = 0;
			if (n < fade) begin
				in_fade = 1'b1;
				fi = n;
			end else if (n < len && len - 1 - n < fade) begin
				in_fade = 1'b1;
				fi = len - 1 - n;
			end
			if (in_fade) begin
				ang = 32'(fi * {1'b0, cfg_fade_step});
				c = sine_of(ang + esg_pkg::QUARTER_TURN);
				gain = (32768 - c) >>> 1;
				s = q15_mul(s, gain);
			end
			last = (n + 1 >= len);
			e.sample = s[15:0];
			e.last = last;
			e.active = 1'b1;
			sw_phase = sw_phase + sw_step;
			nstep = (64'(sw_step) * 64'(cfg_step_ratio)) >> 31;
			if (nstep > 64'hFFFF_FFFF)
				nstep = 64'hFFFF_FFFF;
			sw_step = 32'(nstep);
			sw_count = 24'(n + 1);
			if (last)
				sw_running = 1'b0;
		end
		expected_samples.push_back(e);
	endtask

	// Tick driver.
	always @(posedge clk) begin
		bit busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_sample(s_tdata[0]);
				busy = 0;
			end
			if (!busy) begin
				if (tick_gap > 0) begin
					tick_gap--;
					s_tvalid <= 1'b0;
				end else if (tick_queue.size() > 0) begin
					if (idle_on && $urandom_range(0, 4) == 0) begin
						tick_gap = $urandom_range(0, 6);
						s_tvalid <= 1'b0;
					end else begin
						s_tvalid <= 1'b1;
						s_tdata <= {7'd0, tick_queue.pop_front()};
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sample receiver: random stalls, plus one long hold-off that backs up the block.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				beats_seen++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && beats_seen >= 300) begin
				hold_done = 1;
				hold_left = 600;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Sample checker.
	always @(posedge clk) begin
		sample_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual sample %h last %b active %b",
					$time, m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				e = expected_samples.pop_front();
				if (m_tdata !== e.sample) begin
					$display("%0t: sample mismatch, expected %h actual %h",
						$time, e.sample, m_tdata);
					mismatches++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last_sample mismatch, expected %b actual %b",
						$time, e.last, m_tlast);
					mismatches++;
				end
				if (m_tuser !== e.active) begin
					$display("%0t: active mismatch, expected %b actual %b",
						$time, e.active, m_tuser);
					mismatches++;
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			esg_pkg::REG_START_STEP: cfg_start_step = value[30:0];
			esg_pkg::REG_STEP_RATIO: cfg_step_ratio = value;
			esg_pkg::REG_SWEEP_LEN:  cfg_sweep_len = value[23:0];
			esg_pkg::REG_FADE_LEN:   cfg_fade_len = value[22:0];
			esg_pkg::REG_FADE_STEP:  cfg_fade_step = value[30:0];
			esg_pkg::REG_AMPLITUDE:  cfg_amplitude = value[15:0];
			default: ;
		endcase
	endtask

	// Waits until every tick is taken and every sample is back, then lets the pipeline settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_queue.size() != 0 || s_tvalid || expected_samples.size() != 0);
		repeat (24) @(negedge clk);
	endtask

	task automatic randomize_config();
		logic [31:0] v;
		int unsigned lim;
		case ($urandom_range(0, 3))
			0: v = 32'd0;
			1: v = 32'h7FFF_FFFF;
			2: v = $urandom_range(0, 32'h0100_0000);
			default: v = $urandom;
		endcase
		write_reg(esg_pkg::REG_START_STEP, v);
		case ($urandom_range(0, 3))
			0: v = 32'h8000_0000;
			1: v = 32'hFFFF_FFFF;
			2: v = 32'h8000_0000 + $urandom_range(0, 32'h0100_0000);
			default: v = $urandom;
		endcase
		write_reg(esg_pkg::REG_STEP_RATIO, v);
		case ($urandom_range(0, 15))
			0: v = $urandom_range(0, 15);
			1: v = 32'h00FF_FFFF;
			2: v = $urandom;
			default: v = $urandom_range(16, 64);
		endcase
		write_reg(esg_pkg::REG_SWEEP_LEN, v);
		lim = (cfg_sweep_len > 100) ? 100 : cfg_sweep_len;
		case ($urandom_range(0, 7))
			0, 1: v = 32'd0;
			2, 3: v = $urandom_range(0, lim);
			4: v = 32'h007F_FFFF;
			default: v = $urandom_range(0, lim / 2);
		endcase
		write_reg(esg_pkg::REG_FADE_LEN, v);
		if (cfg_fade_len != 0 && $urandom_range(0, 3) != 0)
			v = 32'h8000_0000 / cfg_fade_len;
		else
			v = $urandom;
		write_reg(esg_pkg::REG_FADE_STEP, v);
		case ($urandom_range(0, 4))
			0: v = 32'h0000_8000;
			1: v = 32'h0000_7FFF;
			2: v = 32'd0;
			default: v = $urandom;
		endcase
		write_reg(esg_pkg::REG_AMPLITUDE, v);
	endtask

	// Mostly whole sweeps with random content, some cut short, a little noise.
	task automatic queue_sweeps(input int count);
		int k, hint;
		hint = (cfg_sweep_len == 0) ? 1 : ((cfg_sweep_len > 90) ? 90 : cfg_sweep_len);
		@(negedge clk);
		while (count > 0) begin
			if ($urandom_range(0, 19) == 0) begin
				tick_queue.push_back(1'($urandom_range(0, 1)));
				count--;
			end else begin
				tick_queue.push_back(1'b1);
				count--;
				if ($urandom_range(0, 9) == 0)
					k = $urandom_range(0, hint);
				else
					k = hint - 1 + $urandom_range(0, 3);
				for (int j = 0; j < k && count > 0; j++) begin
					tick_queue.push_back(1'b0);
					count--;
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle output before any sweep, then the first sample of a sweep at reset settings.
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		wait_drained();

		// Largest step and ratio, fade of exactly half the length, most negative amplitude,
		// run past the end into idle.
		write_reg(esg_pkg::REG_START_STEP, 32'h7FFF_FFFF);
		write_reg(esg_pkg::REG_STEP_RATIO, 32'hFFFF_FFFF);
		write_reg(esg_pkg::REG_SWEEP_LEN, 32'd16);
		write_reg(esg_pkg::REG_FADE_LEN, 32'd8);
		write_reg(esg_pkg::REG_FADE_STEP, 32'h7FFF_FFFF);
		write_reg(esg_pkg::REG_AMPLITUDE, 32'h0000_8000);
		@(negedge clk);
		tick_queue.push_back(1'b1);
		repeat (16) tick_queue.push_back(1'b0);
		wait_drained();

		// Zero length acts as one, oversized fade, ratio below one, zero amplitude.
		write_reg(esg_pkg::REG_START_STEP, 32'd0);
		write_reg(esg_pkg::REG_STEP_RATIO, 32'd0);
		write_reg(esg_pkg::REG_SWEEP_LEN, 32'd0);
		write_reg(esg_pkg::REG_FADE_LEN, 32'h007F_FFFF);
		write_reg(esg_pkg::REG_FADE_STEP, 32'd0);
		write_reg(esg_pkg::REG_AMPLITUDE, 32'd0);
		@(negedge clk);
		tick_queue.push_back(1'b1);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		wait_drained();

		// Longest sweep with the largest fade that fits in half of it.
		write_reg(esg_pkg::REG_START_STEP, 32'h0001_2345);
		write_reg(esg_pkg::REG_STEP_RATIO, 32'h8000_0000);
		write_reg(esg_pkg::REG_SWEEP_LEN, 32'h00FF_FFFF);
		write_reg(esg_pkg::REG_FADE_STEP, 32'd1);
		write_reg(esg_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
		@(negedge clk);
		tick_queue.push_back(1'b1);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b0);
		wait_drained();

		for (int p = 0; p < 12; p++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			randomize_config();
			queue_sweeps(140);
			wait_drained();
		end

		idle_on = 0;
		randomize_config();
		queue_sweeps(70);
		wait_drained();
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
sv/esg_pkg.sv
sv/esg_mul.sv
sv/exponential_sweep_generator.sv
sv/esg_checker.sv
verif/exponential_sweep_generator_tb.sv
